[hw/rtl/lfu_cache_table_unit_assert.svh]
// Assertion macros for the LFU cache table unit.
`ifndef LFU_CACHE_TABLE_UNIT_ASSERT_SVH
`define LFU_CACHE_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define LFU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lfu_cache_table_unit: assertion failed");

// Next-cycle implication, checked out of reset.
`define LFU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lfu_cache_table_unit: assertion failed");

`endif

[hw/rtl/lfu_pkg.sv]
// Shared types and constants of the LFU cache table unit.
`default_nettype none

package lfu_pkg;

  localparam int NUM_ENTRIES = 16;
  localparam int IDX_W       = $clog2(NUM_ENTRIES);
  localparam int AGE_W       = IDX_W;
  localparam int COUNT_W     = 16;
  localparam int KEY_W       = 32;
  localparam int DATA_W      = 32;
  localparam int CAP_W       = 5;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [AGE_W-1:0]   age_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [DATA_W-1:0]  data_t;
  typedef logic [CAP_W-1:0]   cap_t;

  localparam count_t COUNT_MAX   = '1;
  localparam count_t COUNT_ONE   = count_t'(1);
  localparam cap_t   CAP_RESET   = cap_t'(NUM_ENTRIES);
  localparam cap_t   CAP_ENTRIES = cap_t'(NUM_ENTRIES);

  typedef enum logic {
    REQ_GET = 1'b0,
    REQ_PUT = 1'b1
  } req_type_e;

  typedef struct packed {
    idx_t idx;
    age_t age;
  } victim_t;

endpackage

`default_nettype wire

[hw/rtl/lfu_cache_table_unit.sv]
// Top level of the LFU cache table unit: request register, table and result register.
//
// A request (get or put with key and value) is offered on start_i with its fields
// and taken at a clock edge where start_i is high and busy_o is low. busy_o stays
// low, so a request can be taken every cycle. A taken request is held in the
// request register; the next edge updates the table and loads the result
// register. res_valid_o is high for exactly one cycle per result, from the result
// register, with hit_o, read_value_o and evicted_o. Each request yields one
// result, in order. Throughput is one request per cycle; the request register
// and the result register lie around one pass of key compare, victim
// comparison tree and table update.
// Capacity is written with cfg_we_i/cfg_wdata_i; the user must write it only while
// no request is in flight, and the block does not enforce this. A value above the
// table size acts as the table size. Reset clears all valid bits, the pending
// request and result, and sets the capacity to the full table. The receiver cannot
// stall: each result must be taken in its cycle.
`default_nettype none
`include "lfu_cache_table_unit_assert.svh"

module lfu_cache_table_unit import lfu_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic                req_type_i,
  input  logic [KEY_W-1:0]    key_i,
  input  logic [DATA_W-1:0]   value_i,
  input  logic                cfg_we_i,
  input  logic [CAP_W-1:0]    cfg_wdata_i,
  output logic                res_valid_o,
  output logic                hit_o,
  output logic [DATA_W-1:0]   read_value_o,
  output logic                evicted_o
);

  logic      req_valid_q;
  req_type_e req_type_q;
  key_t      req_key_q;
  data_t     req_value_q;
  cap_t      cap_q;

  logic [NUM_ENTRIES-1:0] valid_q, valid_d;
  key_t                   key_q   [NUM_ENTRIES];
  key_t                   key_d   [NUM_ENTRIES];
  data_t                  data_q  [NUM_ENTRIES];
  data_t                  data_d  [NUM_ENTRIES];
  count_t                 count_q [NUM_ENTRIES];
  count_t                 count_d [NUM_ENTRIES];
  age_t                   age_q   [NUM_ENTRIES];
  age_t                   age_d   [NUM_ENTRIES];

  logic  res_valid_q;
  logic  res_hit_q;
  data_t res_value_q;
  logic  res_evicted_q;

  logic [NUM_ENTRIES-1:0] match;
  logic    found_any;
  idx_t    found_idx;
  logic    free_any;
  idx_t    free_idx;
  cap_t    cap_eff;
  cap_t    num_valid;
  logic    req_is_put;
  logic    do_bump;
  logic    do_insert;
  logic    do_evict;
  idx_t    ins_idx;
  age_t    found_age;
  count_t  found_count_inc;
  victim_t victim;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      cap_q       <= CAP_RESET;
    end else begin
      req_valid_q <= start_i && !busy_o;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      req_type_q  <= req_type_e'(req_type_i);
      req_key_q   <= key_i;
      req_value_q <= value_i;
    end
  end

  // Lookup
  always_comb begin
    found_any = 1'b0;
    found_idx = '0;
    free_any  = 1'b0;
    free_idx  = '0;
    for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
      match[i] = valid_q[i] && (key_q[i] == req_key_q);
      if (match[i]) begin
        found_any = 1'b1;
        found_idx = idx_t'(i);
      end
      if (!valid_q[i]) begin
        free_any = 1'b1;
        free_idx = idx_t'(i);
      end
    end
  end

  lfu_victim_sel u_victim_sel (
    .valid_i  (valid_q),
    .count_i  (count_q),
    .age_i    (age_q),
    .victim_o (victim)
  );

  assign num_valid  = cap_t'($countones(valid_q));
  assign cap_eff    = (cap_q > CAP_ENTRIES) ? CAP_ENTRIES : cap_q;
  assign req_is_put = (req_type_q == REQ_PUT);
  assign do_bump    = found_any && (!req_is_put || (cap_eff != '0));
  assign do_insert  = req_is_put && !found_any && (cap_eff != '0);
  assign do_evict   = do_insert && (num_valid >= cap_eff);
  assign ins_idx    = do_evict ? victim.idx : free_idx;
  assign found_age  = age_q[found_idx];
  assign found_count_inc = (count_q[found_idx] == COUNT_MAX) ? COUNT_MAX
                                                             : count_q[found_idx] + 1'b1;

  // Table update
  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    data_d  = data_q;
    count_d = count_q;
    age_d   = age_q;
    if (req_valid_q) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        if (do_bump) begin
          if (idx_t'(i) == found_idx) begin
            count_d[i] = found_count_inc;
            age_d[i]   = '0;
            if (req_is_put) begin
              data_d[i] = req_value_q;
            end
          end else if (valid_q[i] && (age_q[i] < found_age)) begin
            age_d[i] = age_q[i] + 1'b1;
          end
        end else if (do_insert) begin
          if (idx_t'(i) == ins_idx) begin
            valid_d[i] = 1'b1;
            key_d[i]   = req_key_q;
            data_d[i]  = req_value_q;
            count_d[i] = COUNT_ONE;
            age_d[i]   = '0;
          end else if (do_evict && (idx_t'(i) == victim.idx)) begin
            valid_d[i] = 1'b0;
          end else if (valid_q[i] && (!do_evict || (age_q[i] < victim.age))) begin
            age_d[i] = age_q[i] + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      valid_q     <= valid_d;
      res_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    data_q  <= data_d;
    count_q <= count_d;
    age_q   <= age_d;
    if (req_valid_q) begin
      res_hit_q     <= found_any;
      res_value_q   <= (!req_is_put && found_any) ? data_q[found_idx] : '0;
      res_evicted_q <= do_evict;
    end
  end

  assign res_valid_o  = res_valid_q;
  assign hit_o        = res_hit_q;
  assign read_value_o = res_value_q;
  assign evicted_o    = res_evicted_q;

  `LFU_ASSERT_NEXT(a_result_follows_request, req_valid_q, res_valid_o)
  `LFU_ASSERT_NOW(a_evict_needs_miss, res_valid_o && evicted_o, !hit_o)
  `LFU_ASSERT_NOW(a_value_needs_hit, res_valid_o && (read_value_o != '0), hit_o)
  `LFU_ASSERT_NOW(a_victim_is_valid, req_valid_q && do_evict, valid_q[victim.idx])

endmodule

`default_nettype wire

[hw/rtl/lfu_victim_sel.sv]
// Comparison tree that picks the least frequently used, oldest valid entry.
`default_nettype none

module lfu_victim_sel import lfu_pkg::*; (
  input  logic [NUM_ENTRIES-1:0] valid_i,
  input  count_t                 count_i [NUM_ENTRIES],
  input  age_t                   age_i   [NUM_ENTRIES],
  output victim_t                victim_o
);

  localparam int RANK_W    = 1 + COUNT_W + AGE_W;
  localparam int NUM_NODES = 2 * NUM_ENTRIES - 1;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    idx_t              idx;
  } node_t;

  node_t node [NUM_NODES];

  // Lower rank wins: valid first, then lower count, then older entry.
  // Hold free entries at the top rank so their stale fields never reach the compare.
  for (genvar i = 0; i < NUM_ENTRIES; i++) begin : g_leaf
    assign node[NUM_ENTRIES-1+i].rank = valid_i[i] ? {1'b0, count_i[i], ~age_i[i]} : '1;
    assign node[NUM_ENTRIES-1+i].idx  = idx_t'(i);
  end

  // Left child covers lower indices; keep it on a tie.
  for (genvar j = 0; j < NUM_ENTRIES - 1; j++) begin : g_node
    assign node[j] = (node[2*j+2].rank < node[2*j+1].rank) ? node[2*j+2] : node[2*j+1];
  end

  assign victim_o.idx = node[0].idx;
  assign victim_o.age = ~node[0].rank[AGE_W-1:0];

endmodule

`default_nettype wire

[bench/tb_lfu_cache_table_unit.sv]
// Testbench for lfu_cache_table_unit: directed and random get/put traffic checked against a table predictor.
module tb_lfu_cache_table_unit;
  import lfu_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int POOL_SIZE   = 24;
  localparam int SAT_GETS    = 6;
  localparam int PHASE_ITEMS = 90;
  localparam key_t SAT_KEY   = 32'h5A5A_0001;

  typedef struct packed {
    logic  hit;
    data_t read_value;
    logic  evicted;
  } lookup_res_t;

  typedef struct packed {
    req_type_e   kind;
    key_t        key;
    data_t       value;
    logic        typed;
    lookup_res_t res;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  req_type_e   req_type_i;
  key_t        key_i;
  data_t       value_i;
  logic        cfg_we_i;
  cap_t        cfg_wdata_i;
  logic        res_valid_o;
  logic        hit_o;
  data_t       read_value_o;
  logic        evicted_o;

  logic        row_typed;
  lookup_res_t row_res;

  logic        tbl_valid [NUM_ENTRIES];
  key_t        tbl_key   [NUM_ENTRIES];
  data_t       tbl_data  [NUM_ENTRIES];
  count_t      tbl_uses  [NUM_ENTRIES];
  age_t        tbl_age   [NUM_ENTRIES];
  cap_t        cap_shadow;

  lookup_res_t pending_results[$];
  key_t        key_pool [POOL_SIZE];
  int          mismatches;
  int          quiet_cycles;

  localparam lookup_res_t MISS = '{1'b0, 32'h0, 1'b0};

  dir_row_t dir_rows [25] = '{
    '{REQ_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, MISS},
    '{REQ_PUT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, MISS},
    '{REQ_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b1, 32'hFFFF_FFFF, 1'b0}},
    '{REQ_PUT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, MISS},
    '{REQ_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h0000_0000, 1'b0}},
    '{REQ_PUT, 32'h0000_0000, 32'hA5A5_A5A5, 1'b1, '{1'b1, 32'h0000_0000, 1'b0}},
    '{REQ_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b1, 32'hA5A5_A5A5, 1'b0}},
    '{REQ_GET, 32'h1234_5678, 32'h0000_0000, 1'b1, MISS},
    '{REQ_PUT, 32'h0000_0001, 32'h1111_1111, 1'b0, MISS},
    '{REQ_PUT, 32'h8000_0000, 32'h2222_2222, 1'b0, MISS},
    '{REQ_PUT, 32'h5555_5555, 32'h3333_3333, 1'b0, MISS},
    '{REQ_PUT, 32'hAAAA_AAAA, 32'h4444_4444, 1'b0, MISS},
    '{REQ_PUT, 32'h0000_FFFF, 32'h5555_5555, 1'b0, MISS},
    '{REQ_PUT, 32'hFFFF_0000, 32'h6666_6666, 1'b0, MISS},
    '{REQ_PUT, 32'h0F0F_0F0F, 32'h7777_7777, 1'b0, MISS},
    '{REQ_PUT, 32'hF0F0_F0F0, 32'h8888_8888, 1'b0, MISS},
    '{REQ_PUT, 32'hDEAD_BEEF, 32'h9999_9999, 1'b0, MISS},
    '{REQ_PUT, 32'h0000_0100, 32'hAAAA_AAAA, 1'b0, MISS},
    '{REQ_PUT, 32'h7FFF_FFFF, 32'hBBBB_BBBB, 1'b0, MISS},
    '{REQ_PUT, 32'hFFFF_FFFE, 32'hCCCC_CCCC, 1'b0, MISS},
    '{REQ_PUT, 32'h3C3C_3C3C, 32'hDDDD_DDDD, 1'b0, MISS},
    '{REQ_PUT, 32'hC3C3_C3C3, 32'hEEEE_EEEE, 1'b0, MISS},
    '{REQ_PUT, 32'h9999_9999, 32'h0BAD_F00D, 1'b1, '{1'b0, 32'h0000_0000, 1'b1}},
    '{REQ_GET, 32'h0000_0001, 32'h0000_0000, 1'b1, MISS},
    '{REQ_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b1, 32'hA5A5_A5A5, 1'b0}}
  };

  lfu_cache_table_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_type_i  (req_type_i),
    .key_i       (key_i),
    .value_i     (value_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_valid_o (res_valid_o),
    .hit_o       (hit_o),
    .read_value_o(read_value_o),
    .evicted_o   (evicted_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  function automatic void promote(input int e);
    if (tbl_uses[e] != COUNT_MAX) tbl_uses[e]++;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (tbl_valid[i] && i != e && tbl_age[i] < tbl_age[e]) tbl_age[i]++;
    end
    tbl_age[e] = '0;
  endfunction

  function automatic lookup_res_t lfu_lookup(input req_type_e kind, input key_t key,
                                             input data_t value);
    lookup_res_t res;
    int found;
    int free_slot;
    int victim;
    int nvalid;
    int eff_cap;
    age_t gone;
    found = -1;
    free_slot = -1;
    victim = -1;
    nvalid = 0;
    eff_cap = (cap_shadow > NUM_ENTRIES) ? NUM_ENTRIES : int'(cap_shadow);
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (tbl_valid[i]) begin
        nvalid++;
        if (found < 0 && tbl_key[i] == key) found = i;
        if (victim < 0 || tbl_uses[i] < tbl_uses[victim] ||
            (tbl_uses[i] == tbl_uses[victim] && tbl_age[i] > tbl_age[victim]))
          victim = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    res = '{found >= 0, '0, 1'b0};
    if (kind == REQ_GET) begin
      if (found >= 0) begin
        res.read_value = tbl_data[found];
        promote(found);
      end
      return res;
    end
    if (eff_cap == 0) return res;
    if (found >= 0) begin
      tbl_data[found] = value;
      promote(found);
      return res;
    end
    if (nvalid >= eff_cap && victim >= 0) begin
      gone = tbl_age[victim];
      tbl_valid[victim] = 1'b0;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        if (tbl_valid[i] && tbl_age[i] > gone) tbl_age[i]--;
      end
      res.evicted = 1'b1;
      free_slot = victim;
    end
    if (free_slot < 0) return res;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (tbl_valid[i]) tbl_age[i]++;
    end
    tbl_valid[free_slot] = 1'b1;
    tbl_key[free_slot]   = key;
    tbl_data[free_slot]  = value;
    tbl_uses[free_slot]  = COUNT_ONE;
    tbl_age[free_slot]   = '0;
    return res;
  endfunction

  always @(posedge clk_i) begin
    lookup_res_t want;
    lookup_res_t calc;
    if (rst_ni) begin
      if (res_valid_o) begin
        if (pending_results.size() == 0) begin
          flag_mismatch("result with no transaction pending");
        end else begin
          want = pending_results.pop_front();
          if (hit_o !== want.hit)
            flag_mismatch($sformatf("hit %b, want %b", hit_o, want.hit));
          if (read_value_o !== want.read_value)
            flag_mismatch($sformatf("read_value %h, want %h", read_value_o, want.read_value));
          if (evicted_o !== want.evicted)
            flag_mismatch($sformatf("evicted %b, want %b", evicted_o, want.evicted));
        end
      end
      if (cfg_we_i) cap_shadow = cfg_wdata_i;
      if (start_i && !busy_o) begin
        calc = lfu_lookup(req_type_i, key_i, value_i);
        pending_results.push_back(row_typed ? row_res : calc);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || res_valid_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_lfu_cache_table_unit: errors");
      $finish;
    end
  end

  task automatic issue(input req_type_e kind, input key_t key, input data_t value,
                       input logic typed, input lookup_res_t res);
    start_i    <= 1'b1;
    req_type_i <= kind;
    key_i      <= key;
    value_i    <= value;
    row_typed  <= typed;
    row_res    <= res;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic random_item(input int idle_pct);
    int span;
    key_t key;
    req_type_e kind;
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    span = (cap_shadow > NUM_ENTRIES) ? NUM_ENTRIES + 4 : int'(cap_shadow) + 4;
    if (span > POOL_SIZE) span = POOL_SIZE;
    kind = req_type_e'($urandom_range(0, 1));
    if ($urandom_range(0, 9) == 0) key = $urandom;
    else key = key_pool[$urandom_range(0, span - 1)];
    issue(kind, key, $urandom, 1'b0, MISS);
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic set_capacity(input cap_t cap);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    cap_t caps [10] = '{5'd1, 5'd0, 5'd2, 5'd31, 5'd5, 5'd16, 5'd3, 5'd17, 5'd8, 5'd4};
    int   idle_plan [4] = '{0, 49, 15, 0};
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    req_type_i  = REQ_GET;
    key_i       = '0;
    value_i     = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    row_typed   = 1'b0;
    row_res     = MISS;
    mismatches  = 0;
    quiet_cycles = 0;
    cap_shadow  = CAP_RESET;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_key[i]   = '0;
      tbl_data[i]  = '0;
      tbl_uses[i]  = '0;
      tbl_age[i]   = '0;
    end
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = '1;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r])
      issue(dir_rows[r].kind, dir_rows[r].key, dir_rows[r].value, dir_rows[r].typed,
            dir_rows[r].res);

    // keep one key hot so it outlives a run of new puts
    issue(REQ_PUT, SAT_KEY, 32'h600D_CAFE, 1'b0, MISS);
    for (int n = 0; n < SAT_GETS; n++) issue(REQ_GET, SAT_KEY, $urandom, 1'b0, MISS);
    for (int n = 0; n < 20; n++) issue(REQ_PUT, $urandom, $urandom, 1'b0, MISS);
    issue(REQ_GET, SAT_KEY, 32'h0, 1'b0, MISS);

    foreach (caps[p]) begin
      set_capacity(caps[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) random_item(idle_plan[p % 4]);
    end

    drain_results();
    if (mismatches == 0) begin
      $display("tb_lfu_cache_table_unit: clean");
    end else begin
      $display("tb_lfu_cache_table_unit: errors");
    end
    $finish;
  end

endmodule
